// ----- rtl/core/nec_pkg.sv -----
package nec_pkg;

  localparam int STATE_W = 16;
  localparam int SYM_W = 4;
  localparam int CFG_W = 16;
  localparam int CFG_IDX_W = 2;
  localparam int MAX_STATES_DEF = 16;
  localparam int MAX_SYMBOLS_DEF = 16;

  typedef enum logic [1:0] {
    CMD_WRITE_ROW = 2'd0,
    CMD_START     = 2'd1,
    CMD_FEED      = 2'd2,
    CMD_NONE      = 2'd3
  } cmd_t;

  localparam logic [CFG_IDX_W-1:0] CFG_FINAL_MASK   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STATE_COUNT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SYMBOL_COUNT = 2'd2;

  typedef struct packed {
    logic [15:0] final_mask;
    logic [4:0]  state_count;
    logic [3:0]  symbol_count;
  } cfg_t;

  typedef struct packed {
    logic        accepted;
    logic        bad_symbol;
    logic [15:0] active_states;
  } result_t;

endpackage

// ----- rtl/core/nec_ram.sv -----
module nec_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/nec_engine.sv -----
module nec_engine #(
  parameter int MAX_STATES = nec_pkg::MAX_STATES_DEF,
  parameter int MAX_SYMBOLS = nec_pkg::MAX_SYMBOLS_DEF,
  localparam int DEPTH = MAX_STATES * MAX_SYMBOLS,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [1:0]                   command,
  input  logic [nec_pkg::SYM_W-1:0]    from_state,
  input  logic [nec_pkg::SYM_W-1:0]    symbol,
  input  logic [nec_pkg::STATE_W-1:0]  target_mask,
  input  nec_pkg::cfg_t                cfg,
  output logic                         busy,
  output logic                         done,
  output nec_pkg::result_t             res,
  output logic                         mem_we,
  output logic [AW-1:0]                mem_waddr,
  output logic [nec_pkg::STATE_W-1:0]  mem_wdata,
  output logic [AW-1:0]                mem_raddr,
  input  logic [nec_pkg::STATE_W-1:0]  mem_rdata
);
  import nec_pkg::*;

  typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_MOVE, S_CLOSE} state_t;

  state_t               state;
  logic [AW-1:0]        clr_addr;
  logic [STATE_W-1:0]   act;
  logic [STATE_W-1:0]   work;
  logic [STATE_W-1:0]   pend;
  logic [SYM_W-1:0]     sym_r;
  logic                 inflight;

  logic [STATE_W-1:0]   live;
  logic [SYM_W-1:0]     idx;
  logic                 issue;
  logic [STATE_W-1:0]   issued_bit;
  logic [STATE_W-1:0]   add;
  logic [STATE_W-1:0]   work_upd;
  logic [STATE_W-1:0]   pend_upd;
  logic                 accept;
  logic                 sym_bad;
  logic                 row_ok;
  logic                 walk_done;

  function automatic logic [AW-1:0] row_addr(input logic [SYM_W-1:0] r,
                                             input logic [SYM_W-1:0] s);
    return AW'(int'(r) * MAX_SYMBOLS + int'(s));
  endfunction

  function automatic logic [SYM_W-1:0] lowest(input logic [STATE_W-1:0] v);
    logic [SYM_W-1:0] k;
    k = '0;
    for (int j = STATE_W - 1; j >= 0; j--) begin
      if (v[j]) begin
        k = SYM_W'(j);
      end
    end
    return k;
  endfunction

  always_comb begin
    for (int j = 0; j < STATE_W; j++) begin
      live[j] = (5'(j) < cfg.state_count) && (j < MAX_STATES);
    end
  end

  assign idx        = lowest(pend);
  assign issue      = ((state == S_MOVE) || (state == S_CLOSE)) && (pend != '0);
  assign issued_bit = issue ? (STATE_W'(1) << idx) : '0;
  assign add        = inflight ? (mem_rdata & live & ~work) : '0;
  assign work_upd   = work | add;
  assign pend_upd   = (pend & ~issued_bit) | ((state == S_CLOSE) ? add : '0);
  assign walk_done  = (pend == '0) && !inflight;

  assign accept  = start && (state == S_IDLE);
  assign sym_bad = (symbol == '0) || (symbol > cfg.symbol_count) ||
                   (32'(symbol) >= MAX_SYMBOLS);
  assign row_ok  = (32'(from_state) < MAX_STATES) && (32'(symbol) < MAX_SYMBOLS);

  assign busy      = (state != S_IDLE);
  assign mem_we    = (state == S_CLEAR) ||
                     (accept && (command == CMD_WRITE_ROW) && row_ok);
  assign mem_waddr = (state == S_CLEAR) ? clr_addr : row_addr(from_state, symbol);
  assign mem_wdata = (state == S_CLEAR) ? '0 : target_mask;
  assign mem_raddr = row_addr(idx, (state == S_MOVE) ? sym_r : '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
      act      <= '0;
      pend     <= '0;
      inflight <= 1'b0;
      done     <= 1'b0;
    end else begin
      done     <= 1'b0;
      inflight <= issue;
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == AW'(DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            case (command)
              CMD_START: begin
                work  <= live & STATE_W'(1);
                pend  <= live & STATE_W'(1);
                state <= S_CLOSE;
              end
              CMD_FEED: begin
                if (sym_bad) begin
                  act               <= '0;
                  res.accepted      <= 1'b0;
                  res.bad_symbol    <= 1'b1;
                  res.active_states <= '0;
                  done              <= 1'b1;
                end else begin
                  work  <= '0;
                  pend  <= act & live;
                  sym_r <= symbol;
                  state <= S_MOVE;
                end
              end
              default: begin
                res.accepted      <= |(act & cfg.final_mask);
                res.bad_symbol    <= 1'b0;
                res.active_states <= act;
                done              <= 1'b1;
              end
            endcase
          end
        end
        S_MOVE: begin
          work <= work_upd;
          pend <= walk_done ? work : pend_upd;
          if (walk_done) begin
            state <= S_CLOSE;
          end
        end
        S_CLOSE: begin
          work <= work_upd;
          pend <= pend_upd;
          if (walk_done) begin
            act               <= work;
            res.accepted      <= |(work & cfg.final_mask);
            res.bad_symbol    <= 1'b0;
            res.active_states <= work;
            done              <= 1'b1;
            state             <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- rtl/core/nfa_epsilon_closure_matcher.sv -----
// row write, unused command or bad symbol: result in the cycle after start is taken
// start string: the epsilon closure of state 0 becomes the new active set
// feed symbol: live active states move on the symbol, then the epsilon closure is taken;
// one table row per cycle, plus a wait when only a pending read can add states
// one item at a time (busy high while working); results cannot be stalled
// reset: config to defaults, active set cleared, then all MAX_STATES*MAX_SYMBOLS table rows cleared
module nfa_epsilon_closure_matcher #(
  parameter int MAX_STATES = nec_pkg::MAX_STATES_DEF,
  parameter int MAX_SYMBOLS = nec_pkg::MAX_SYMBOLS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic [1:0]                     command,
  input  logic [nec_pkg::SYM_W-1:0]      from_state,
  input  logic [nec_pkg::SYM_W-1:0]      symbol,
  input  logic [nec_pkg::STATE_W-1:0]    target_mask,
  output logic                           done,
  output logic                           accepted,
  output logic                           bad_symbol,
  output logic [nec_pkg::STATE_W-1:0]    active_states,
  input  logic                           cfg_write,
  input  logic [nec_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [nec_pkg::CFG_W-1:0]      cfg_data
);
  import nec_pkg::*;

  localparam int DEPTH = MAX_STATES * MAX_SYMBOLS;
  localparam int AW = $clog2(DEPTH);

  cfg_t                cfg;
  result_t             res;
  logic                mem_we;
  logic [AW-1:0]       mem_waddr;
  logic [STATE_W-1:0]  mem_wdata;
  logic [AW-1:0]       mem_raddr;
  logic [STATE_W-1:0]  mem_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.final_mask   <= '0;
      cfg.state_count  <= 5'd16;
      cfg.symbol_count <= 4'd15;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_FINAL_MASK:   cfg.final_mask   <= cfg_data[15:0];
        CFG_STATE_COUNT:  cfg.state_count  <= cfg_data[4:0];
        CFG_SYMBOL_COUNT: cfg.symbol_count <= cfg_data[3:0];
        default: begin
        end
      endcase
    end
  end

  nec_engine #(
    .MAX_STATES (MAX_STATES),
    .MAX_SYMBOLS(MAX_SYMBOLS)
  ) u_engine (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .command    (command),
    .from_state (from_state),
    .symbol     (symbol),
    .target_mask(target_mask),
    .cfg        (cfg),
    .busy       (busy),
    .done       (done),
    .res        (res),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata),
    .mem_raddr  (mem_raddr),
    .mem_rdata  (mem_rdata)
  );

  nec_ram #(
    .WIDTH(STATE_W),
    .DEPTH(DEPTH)
  ) u_table (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  assign accepted      = res.accepted;
  assign bad_symbol    = res.bad_symbol;
  assign active_states = res.active_states;

endmodule

// ----- rtl/core/nec_checker.sv -----
module nec_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         start,
  input logic                         busy,
  input logic                         done,
  input logic                         accepted,
  input logic                         bad_symbol,
  input logic [nec_pkg::STATE_W-1:0]  active_states
);

  // an accepted item either finishes at once or keeps the block busy
  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> done || busy)
    else $error("accepted item neither finished nor busy");

  // results only come out as the block goes idle
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result while busy");

  // no result without an item
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    !busy && !start |=> !done)
    else $error("result without an accepted item");

  a_bad_clears: assert property (@(posedge clk) disable iff (rst)
    done && bad_symbol |-> active_states == '0 && !accepted)
    else $error("bad symbol left states active");

  // table clear pass follows reset
  a_reset_clear: assert property (@(posedge clk)
    rst |=> busy && !done)
    else $error("not busy after reset");

endmodule

bind nfa_epsilon_closure_matcher nec_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .done         (done),
  .accepted     (accepted),
  .bad_symbol   (bad_symbol),
  .active_states(active_states)
);

// ----- tb/tb_nfa_epsilon_closure_matcher.sv -----
module tb_nfa_epsilon_closure_matcher;
  timeunit 1ns;
  timeprecision 1ps;

  import nec_pkg::*;

  localparam int ITEM_GOAL      = 1350;
  localparam int QUIET_FROM     = 1150;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int SETTLE_CYCLES  = 60;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 start = 1'b0;
  logic                 busy;
  cmd_t                 command = CMD_NONE;
  logic [SYM_W-1:0]     from_state = '0;
  logic [SYM_W-1:0]     symbol = '0;
  logic [STATE_W-1:0]   target_mask = '0;
  logic                 done;
  logic                 accepted;
  logic                 bad_symbol;
  logic [STATE_W-1:0]   active_states;
  logic                 cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  nfa_epsilon_closure_matcher dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .command(command),
    .from_state(from_state),
    .symbol(symbol),
    .target_mask(target_mask),
    .done(done),
    .accepted(accepted),
    .bad_symbol(bad_symbol),
    .active_states(active_states),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  // predictor copy of the automaton
  logic [15:0] row_mem [16][16];
  logic [15:0] live_set;
  logic [15:0] acc_mask;
  logic [4:0]  n_states;
  logic [3:0]  max_sym;

  result_t expected_results[$];
  result_t want;
  int mismatches = 0;
  int items_sent = 0;
  int results_seen = 0;
  int cfg_writes = 0;
  int strings_run = 0;
  int stall_cycles = 0;
  int idle_odds = 0;
  bit quiet = 1'b0;

  function automatic logic [15:0] in_use_mask();
    int n;
    n = (n_states > 16) ? 16 : int'(n_states);
    if (n >= 16) return 16'hffff;
    return (16'd1 << n) - 16'd1;
  endfunction

  function automatic logic [15:0] move_set(input logic [15:0] set, input logic [3:0] sym);
    logic [15:0] m;
    logic [15:0] r;
    m = in_use_mask();
    r = '0;
    for (int i = 0; i < 16; i++)
      if (set[i] && m[i]) r |= row_mem[i][sym];
    return r & m;
  endfunction

  function automatic logic [15:0] epsilon_closure(input logic [15:0] set);
    logic [15:0] cur;
    logic [15:0] nxt;
    cur = set & in_use_mask();
    nxt = cur | move_set(cur, 4'd0);
    while (nxt != cur) begin
      cur = nxt;
      nxt = cur | move_set(cur, 4'd0);
    end
    return cur;
  endfunction

  function automatic result_t predict_item(input cmd_t c, input logic [3:0] f,
                                           input logic [3:0] s, input logic [15:0] m);
    result_t res;
    logic bad;
    bad = 1'b0;
    case (c)
      CMD_WRITE_ROW: row_mem[f][s] = m;
      CMD_START: live_set = epsilon_closure(16'd1);
      CMD_FEED: begin
        if (s == 4'd0 || s > max_sym) begin
          bad = 1'b1;
          live_set = '0;
        end else begin
          live_set = epsilon_closure(move_set(live_set, s));
        end
      end
      default: ;
    endcase
    res.accepted = |(live_set & acc_mask);
    res.bad_symbol = bad;
    res.active_states = live_set;
    return res;
  endfunction

  function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
    case (idx)
      CFG_FINAL_MASK:   acc_mask = data;
      CFG_STATE_COUNT:  n_states = data[4:0];
      CFG_SYMBOL_COUNT: max_sym = data[3:0];
      default: ;
    endcase
  endfunction

  function automatic logic [15:0] sparse_targets(input int n);
    logic [15:0] m;
    case ($urandom_range(0, 9))
      0: m = '0;
      1: m = 16'($urandom);
      default: begin
        m = 16'd1 << $urandom_range(0, n - 1);
        if ($urandom_range(0, 1)) m |= 16'd1 << $urandom_range(0, n - 1);
      end
    endcase
    return m;
  endfunction

  // leaves start high, unless it draws a random idle gap, so a following item goes out back to back
  task automatic send_item(input cmd_t c, input logic [3:0] f, input logic [3:0] s,
                           input logic [15:0] m);
    start <= 1'b1;
    command <= c;
    from_state <= f;
    symbol <= s;
    target_mask <= m;
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_results.push_back(predict_item(c, f, s, m));
    items_sent++;
    if (c == CMD_START) strings_run++;
    if (!quiet && idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    apply_reg(idx, data);
    cfg_writes++;
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  task automatic test_reset_defaults();
    wait_idle();
    send_item(CMD_NONE, 4'd0, 4'd0, 16'h0000);
    send_item(CMD_START, 4'd0, 4'd0, 16'h0000);
    send_item(CMD_FEED, 4'd0, 4'd15, 16'h0000);
    send_item(CMD_FEED, 4'd0, 4'd0, 16'h0000);
  endtask

  task automatic test_register_extremes();
    wait_idle();
    write_reg(CFG_FINAL_MASK, 16'hffff);
    write_reg(CFG_STATE_COUNT, 16'd16);
    write_reg(CFG_SYMBOL_COUNT, 16'd15);
    // epsilon chain 0 -> 1 -> 2, then 2 -> 15 and 15 -> everything on the top symbol
    send_item(CMD_WRITE_ROW, 4'd0, 4'd0, 16'h0002);
    send_item(CMD_WRITE_ROW, 4'd1, 4'd0, 16'h0004);
    send_item(CMD_WRITE_ROW, 4'd2, 4'd15, 16'h8000);
    send_item(CMD_WRITE_ROW, 4'd15, 4'd15, 16'hffff);
    send_item(CMD_START, 4'd15, 4'd15, 16'hffff);
    send_item(CMD_FEED, 4'd0, 4'd15, 16'h0000);
    send_item(CMD_FEED, 4'd0, 4'd15, 16'h0000);
    send_item(CMD_NONE, 4'd15, 4'd15, 16'hffff);
    // row write mid string leaves the set alone
    send_item(CMD_WRITE_ROW, 4'd0, 4'd1, 16'h0000);
    send_item(CMD_FEED, 4'd0, 4'd1, 16'h0000);

    // no state in use
    wait_idle();
    write_reg(CFG_STATE_COUNT, 16'd0);
    send_item(CMD_START, 4'd0, 4'd0, 16'h0000);
    send_item(CMD_FEED, 4'd0, 4'd1, 16'h0000);

    // state count above the table size, no valid symbol
    wait_idle();
    write_reg(CFG_STATE_COUNT, 16'hffff);
    write_reg(CFG_SYMBOL_COUNT, 16'hfff0);
    send_item(CMD_START, 4'd0, 4'd0, 16'h0000);
    send_item(CMD_FEED, 4'd0, 4'd1, 16'h0000);

    // single state, single symbol, nothing accepting
    wait_idle();
    write_reg(CFG_SYMBOL_COUNT, 16'd1);
    write_reg(CFG_STATE_COUNT, 16'd1);
    write_reg(CFG_FINAL_MASK, 16'h0000);
    write_reg(CFG_UNUSED, 16'h5a5a);
    send_item(CMD_START, 4'd0, 4'd0, 16'h0000);
    send_item(CMD_FEED, 4'd0, 4'd2, 16'h0000);
    send_item(CMD_FEED, 4'd0, 4'd1, 16'h0000);
  endtask

  task automatic test_random_automata();
    int live;
    int sym_top;
    int len;
    int r;
    int sc;
    int sy;
    logic [15:0] data;
    logic [3:0] fed;
    while (items_sent < ITEM_GOAL) begin
      quiet = (items_sent >= QUIET_FROM);
      case ($urandom_range(0, 2))
        0: idle_odds = 0;
        1: idle_odds = 3;
        default: idle_odds = 8;
      endcase
      wait_idle();

      data = 16'($urandom);
      if ($urandom_range(0, 7) == 0) data = $urandom_range(0, 1) ? 16'h0000 : 16'hffff;
      write_reg(CFG_FINAL_MASK, data);
      sc = ($urandom_range(0, 9) < 7) ? $urandom_range(2, 16) : $urandom_range(0, 31);
      write_reg(CFG_STATE_COUNT, {11'($urandom), 5'(sc)});
      sy = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 5) : $urandom_range(0, 15);
      write_reg(CFG_SYMBOL_COUNT, {12'($urandom), 4'(sy)});

      // fresh automaton over the states in use, low symbols only
      live = (n_states > 16) ? 16 : int'(n_states);
      if (live == 0) live = 1;
      sym_top = (max_sym > 4) ? 4 : int'(max_sym);
      for (int st = 0; st < live; st++)
        for (int sm = 0; sm <= sym_top; sm++)
          send_item(CMD_WRITE_ROW, 4'(st), 4'(sm),
                    (sm == 0 && $urandom_range(0, 2) != 0) ? 16'h0000 : sparse_targets(live));
      repeat ($urandom_range(0, 3))
        send_item(CMD_WRITE_ROW, 4'($urandom), 4'($urandom), 16'($urandom));

      repeat ($urandom_range(3, 8)) begin
        send_item(CMD_START, 4'($urandom), 4'($urandom), 16'($urandom));
        len = $urandom_range(0, 12);
        repeat (len) begin
          r = $urandom_range(0, 39);
          if (r == 0) begin
            send_item(CMD_NONE, 4'($urandom), 4'($urandom), 16'($urandom));
          end else if (r == 1) begin
            send_item(CMD_WRITE_ROW, 4'($urandom), 4'($urandom), sparse_targets(live));
          end else begin
            if (r < 5 || max_sym == 4'd0) fed = 4'($urandom);
            else fed = 4'($urandom_range(1, max_sym));
            send_item(CMD_FEED, 4'($urandom), fed, 16'($urandom));
          end
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        $error("result with no item outstanding, active_states %h", active_states);
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        if (accepted !== want.accepted) begin
          $error("accepted: expected %0b, got %0b", want.accepted, accepted);
          mismatches++;
        end
        if (bad_symbol !== want.bad_symbol) begin
          $error("bad_symbol: expected %0b, got %0b", want.bad_symbol, bad_symbol);
          mismatches++;
        end
        if (active_states !== want.active_states) begin
          $error("active_states: expected %h, got %h", want.active_states, active_states);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || done || cfg_write) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no progress for %0d cycles", WATCHDOG_LIMIT);
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < 16; i++)
      for (int j = 0; j < 16; j++)
        row_mem[i][j] = '0;
    live_set = '0;
    acc_mask = '0;
    n_states = 5'd16;
    max_sym = 4'd15;

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_register_extremes();
    test_random_automata();

    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("covered %0d items and %0d results over %0d strings", items_sent, results_seen,
             strings_run);
    $display("with %0d register writes, counts and masks at their extremes", cfg_writes);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ----- nfa_epsilon_closure_matcher.f -----
rtl/core/nec_pkg.sv
rtl/core/nec_ram.sv
rtl/core/nec_engine.sv
rtl/core/nfa_epsilon_closure_matcher.sv
rtl/core/nec_checker.sv
tb/tb_nfa_epsilon_closure_matcher.sv
